/* design/gsp_pkg.sv */
// ----------------------------------------------------------------------------
// gsp_pkg
// Shared constants and types for the generational slot pool.
// ----------------------------------------------------------------------------
`default_nettype none

package gsp_pkg;

  localparam int SLOT_COUNT = 256;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int HW_W       = SLOT_W + 1;
  localparam int GEN_BITS   = 16;

  typedef logic [SLOT_W-1:0]   slot_t;
  typedef logic [GEN_BITS-1:0] gen_t;
  typedef logic [1:0]          status_t;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_REMOVE = 3'd1,
    OP_LOOKUP = 3'd2,
    OP_FIRST  = 3'd3,
    OP_NEXT   = 3'd4
  } opcode_t;

  localparam status_t STAT_OK    = 2'd0;
  localparam status_t STAT_FULL  = 2'd1;
  localparam status_t STAT_STALE = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LINK
  } state_t;

endpackage

`default_nettype wire

/* design/gsp_ram.sv */
// ----------------------------------------------------------------------------
// gsp_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* design/generational_slot_pool.sv */
// ----------------------------------------------------------------------------
// generational_slot_pool
// Slot pool with generation-checked handles, a free list and a live list.
// ----------------------------------------------------------------------------
// A word is accepted on start while busy is low. An add or a remove that
// goes ahead passes through the EXEC and LINK states, and out_valid rises as
// LINK ends. For lookup, first, next, unknown opcodes, a full add and a stale
// remove it rises as EXEC ends. busy drops in the strobe cycle and the next
// word is taken at the edge that ends it, so a new word is only taken once the
// last one is through. LINK is needed because each link memory has a single
// write port: an add or a remove can write the next-link memory twice.
// out_valid is high for exactly one cycle per word and the receiver cannot
// stall it. The generation store also holds the live bit of each slot. It is
// cleared at reset through per-slot valid bits, so there is no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module generational_slot_pool (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [2:0]        in_opcode,
  input  wire gsp_pkg::slot_t    in_handle_slot,
  input  wire gsp_pkg::gen_t     in_handle_generation,
  output logic                   out_valid,
  output gsp_pkg::slot_t         out_result_slot,
  output gsp_pkg::gen_t          out_result_generation,
  output gsp_pkg::status_t       out_status
);

  import gsp_pkg::*;

  state_t state_r, state_nxt;

  logic [2:0]          op_r;
  slot_t               hs_r;
  gen_t                hg_r;
  slot_t               slot_r;
  logic                from_free_r;
  logic                full_r;

  slot_t               head_r, head_nxt;
  slot_t               tail_r, tail_nxt;
  slot_t               free_head_r, free_head_nxt;
  logic [HW_W-1:0]     hw_r, hw_nxt;
  logic [SLOT_COUNT-1:0] gen_ok_r, gen_ok_nxt;

  logic                out_valid_r;
  slot_t               out_slot_r;
  gen_t                out_gen_r;
  status_t             out_status_r;

  logic                accept;
  slot_t               pick_slot;
  logic                pick_free;
  logic                pick_full;
  slot_t               raddr;

  slot_t               next_rdata, prev_rdata;
  logic [GEN_BITS:0]   gen_rdata;
  logic [GEN_BITS:0]   gen_ent;
  gen_t                gen_cur;
  logic                live_cur;
  logic                handle_ok;

  logic                next_we, prev_we, gen_we;
  slot_t               next_waddr, prev_waddr;
  slot_t               next_wdata, prev_wdata;
  logic [GEN_BITS:0]   gen_wdata;

  logic                done;
  slot_t               res_slot;
  gen_t                res_gen;
  status_t             res_status;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  // slot choice for add: free list first, then the never-used region
  assign pick_free = (free_head_r != '0);
  assign pick_full = !pick_free && (hw_r == HW_W'(SLOT_COUNT));
  assign pick_slot = pick_free ? free_head_r : hw_r[SLOT_W-1:0];

  assign raddr = (state_r == S_IDLE)
               ? ((in_opcode == OP_ADD) ? pick_slot : in_handle_slot)
               : slot_r;

  // generation store entry: live bit on top of the generation
  assign gen_ent   = gen_ok_r[slot_r] ? gen_rdata : '0;
  assign gen_cur   = gen_ent[GEN_BITS-1:0];
  assign live_cur  = gen_ent[GEN_BITS];
  assign handle_ok = (hs_r != '0) && live_cur && (gen_cur == hg_r);

  gsp_ram #(.WIDTH(SLOT_W), .DEPTH(SLOT_COUNT)) u_next_ram (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr),
    .wdata (next_wdata),
    .raddr (raddr),
    .rdata (next_rdata)
  );

  gsp_ram #(.WIDTH(SLOT_W), .DEPTH(SLOT_COUNT)) u_prev_ram (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_waddr),
    .wdata (prev_wdata),
    .raddr (raddr),
    .rdata (prev_rdata)
  );

  gsp_ram #(.WIDTH(GEN_BITS + 1), .DEPTH(SLOT_COUNT)) u_gen_ram (
    .clk   (clk),
    .we    (gen_we),
    .waddr (slot_r),
    .wdata (gen_wdata),
    .raddr (raddr),
    .rdata (gen_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (op_r == OP_ADD && !full_r) begin
          state_nxt = S_LINK;
        end else if (op_r == OP_REMOVE && handle_ok) begin
          state_nxt = S_LINK;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_LINK: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    done          = 1'b0;
    res_slot      = '0;
    res_gen       = '0;
    res_status    = STAT_OK;
    next_we       = 1'b0;
    next_waddr    = slot_r;
    next_wdata    = '0;
    prev_we       = 1'b0;
    prev_waddr    = slot_r;
    prev_wdata    = '0;
    gen_we        = 1'b0;
    gen_wdata     = {1'b0, gen_cur + GEN_BITS'(1)};
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    free_head_nxt = free_head_r;
    hw_nxt        = hw_r;
    gen_ok_nxt    = gen_ok_r;
    case (state_r)
      S_EXEC: begin
        case (op_r)
          OP_ADD: begin
            if (full_r) begin
              done       = 1'b1;
              res_status = STAT_FULL;
            end else begin
              if (from_free_r) begin
                free_head_nxt = next_rdata;
              end else begin
                hw_nxt = hw_r + HW_W'(1);
              end
              next_we    = 1'b1;
              next_wdata = '0;
              prev_we    = 1'b1;
              prev_wdata = tail_r;
            end
          end
          OP_REMOVE: begin
            if (!handle_ok) begin
              done       = 1'b1;
              res_status = STAT_STALE;
            end else begin
              // unlink: predecessor skips to successor and back
              if (prev_rdata == '0) begin
                head_nxt = next_rdata;
              end else begin
                next_we    = 1'b1;
                next_waddr = prev_rdata;
                next_wdata = next_rdata;
              end
              if (next_rdata == '0) begin
                tail_nxt = prev_rdata;
              end else begin
                prev_we    = 1'b1;
                prev_waddr = next_rdata;
                prev_wdata = prev_rdata;
              end
              gen_we             = 1'b1;
              gen_ok_nxt[slot_r] = 1'b1;
            end
          end
          OP_LOOKUP: begin
            done = 1'b1;
            if (handle_ok) begin
              res_slot = hs_r;
            end else begin
              res_status = STAT_STALE;
            end
          end
          OP_FIRST: begin
            done     = 1'b1;
            res_slot = head_r;
          end
          OP_NEXT: begin
            done = 1'b1;
            if (hs_r == '0) begin
              res_slot = head_r;
            end else if (live_cur) begin
              res_slot = next_rdata;
            end else begin
              res_status = STAT_STALE;
            end
          end
          default: begin
            done       = 1'b1;
            res_status = STAT_STALE;
          end
        endcase
      end
      S_LINK: begin
        done     = 1'b1;
        res_slot = slot_r;
        if (op_r == OP_ADD) begin
          if (tail_r == '0) begin
            head_nxt = slot_r;
          end else begin
            next_we    = 1'b1;
            next_waddr = tail_r;
            next_wdata = slot_r;
          end
          tail_nxt           = slot_r;
          gen_we             = 1'b1;
          gen_wdata          = {1'b1, gen_cur};
          gen_ok_nxt[slot_r] = 1'b1;
          res_gen            = gen_cur;
        end else begin
          next_we       = 1'b1;
          next_wdata    = free_head_r;
          prev_we       = 1'b1;
          prev_wdata    = '0;
          free_head_nxt = slot_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      free_head_r <= '0;
      hw_r        <= HW_W'(1);
      gen_ok_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      free_head_r <= free_head_nxt;
      hw_r        <= hw_nxt;
      gen_ok_r    <= gen_ok_nxt;
      out_valid_r <= done;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r        <= in_opcode;
      hs_r        <= in_handle_slot;
      hg_r        <= in_handle_generation;
      slot_r      <= raddr;
      from_free_r <= pick_free;
      full_r      <= pick_full;
    end
    if (done) begin
      out_slot_r   <= res_slot;
      out_gen_r    <= res_gen;
      out_status_r <= res_status;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_result_slot       = out_slot_r;
  assign out_result_generation = out_gen_r;
  assign out_status            = out_status_r;

  a_add_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && op_r == OP_ADD && out_status_r == STAT_OK) |-> (tail_r == out_slot_r))
    else $error("added slot not at the live list tail");

  a_list_ends: assert property (@(posedge clk) disable iff (!rst_n)
    ((head_r == '0) == (tail_r == '0)))
    else $error("live list head and tail disagree on emptiness");

  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobes in adjacent cycles");

  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted word without going busy");

endmodule

`default_nettype wire

/* sim/tb_generational_slot_pool.sv */
// ----------------------------------------------------------------------------
// tb_generational_slot_pool
// Self-checking testbench for the generational slot pool.
// ----------------------------------------------------------------------------
// A short table of directed words covers reset state, stale handles, unknown
// opcodes, list walking and free-list reuse. Random traffic follows, mostly
// well-formed handles with some noise. A fill pass drives the pool to full,
// and a churn pass recycles one slot through remove and add. Every accepted
// word is run through a local model of the pool, and each result strobe is
// compared field by field with the oldest pending expectation. Sender gaps are
// drawn per word, with bursts of back-to-back traffic between them.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_generational_slot_pool;
  timeunit 1ns;
  timeprecision 1ps;

  import gsp_pkg::*;

  localparam logic [2:0] OP_BAD5 = 3'd5;
  localparam logic [2:0] OP_BAD7 = 3'd7;
  localparam int IDLE_LIMIT = 2000;
  localparam int RAND_WORDS = 420;
  localparam int CHURN_ROUNDS = 40;

  typedef struct packed {
    slot_t   slot;
    gen_t    gen;
    status_t status;
  } pool_res_t;

  typedef struct packed {
    logic [2:0] op;
    slot_t      hs;
    gen_t       hg;
    logic       typed;
    pool_res_t  res;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic [2:0] in_opcode = '0;
  slot_t      in_handle_slot = '0;
  gen_t       in_handle_generation = '0;
  logic       busy;
  logic       out_valid;
  slot_t      out_result_slot;
  gen_t       out_result_generation;
  status_t    out_status;

  // model of the pool
  slot_t      nxt_link [SLOT_COUNT];
  slot_t      prv_link [SLOT_COUNT];
  gen_t       slot_gen [SLOT_COUNT];
  logic       slot_live [SLOT_COUNT];
  logic [8:0] high_mark;
  slot_t      free_top;

  pool_res_t  pending_results [$];
  pool_res_t  want;
  dir_row_t   dir_tab [$];

  int errors = 0;
  int words_sent = 0;
  int results_seen = 0;
  int full_seen = 0;
  int stale_seen = 0;
  int idle_cycles = 0;
  logic no_idle = 1'b0;
  logic burst = 1'b0;
  slot_t walk_pos = '0;

  generational_slot_pool DUT (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_opcode             (in_opcode),
    .in_handle_slot        (in_handle_slot),
    .in_handle_generation  (in_handle_generation),
    .out_valid             (out_valid),
    .out_result_slot       (out_result_slot),
    .out_result_generation (out_result_generation),
    .out_status            (out_status)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic handle_ok(slot_t hs, gen_t hg);
    return hs != '0 && slot_live[hs] && slot_gen[hs] == hg;
  endfunction

  function automatic pool_res_t pool_update(logic [2:0] op, slot_t hs, gen_t hg);
    pool_res_t r;
    slot_t     s;
    slot_t     tail;
    slot_t     nx;
    slot_t     pv;
    logic      got;
    r = '{slot: '0, gen: '0, status: STAT_STALE};
    got = 1'b0;
    s = '0;
    case (op)
      OP_ADD: begin
        if (free_top != '0) begin
          s = free_top;
          free_top = nxt_link[s];
          got = 1'b1;
        end else if (high_mark < SLOT_COUNT) begin
          s = high_mark[SLOT_W-1:0];
          high_mark = high_mark + 9'd1;
          got = 1'b1;
        end
        if (!got) begin
          r.status = STAT_FULL;
        end else begin
          tail = prv_link[0];
          prv_link[s] = tail;
          nxt_link[s] = '0;
          nxt_link[tail] = s;
          prv_link[0] = s;
          slot_live[s] = 1'b1;
          r = '{slot: s, gen: slot_gen[s], status: STAT_OK};
        end
      end
      OP_REMOVE: begin
        if (handle_ok(hs, hg)) begin
          nx = nxt_link[hs];
          pv = prv_link[hs];
          nxt_link[pv] = nx;
          prv_link[nx] = pv;
          nxt_link[hs] = free_top;
          prv_link[hs] = '0;
          slot_gen[hs] = slot_gen[hs] + 1'b1;
          slot_live[hs] = 1'b0;
          free_top = hs;
          r = '{slot: hs, gen: '0, status: STAT_OK};
        end
      end
      OP_LOOKUP: begin
        if (handle_ok(hs, hg)) r = '{slot: hs, gen: '0, status: STAT_OK};
      end
      OP_FIRST: begin
        r = '{slot: nxt_link[0], gen: '0, status: STAT_OK};
      end
      OP_NEXT: begin
        if (hs == '0) r = '{slot: nxt_link[0], gen: '0, status: STAT_OK};
        else if (slot_live[hs]) r = '{slot: nxt_link[hs], gen: '0, status: STAT_OK};
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic slot_t pick_live();
    int base;
    slot_t s;
    base = $urandom_range(1, SLOT_COUNT - 1);
    for (int i = 0; i < SLOT_COUNT; i++) begin
      s = slot_t'(base + i);
      if (s != '0 && slot_live[s]) return s;
    end
    return '0;
  endfunction

  // present one word, wait for acceptance, then record what it should return
  task automatic send_word(input logic [2:0] op, input slot_t hs, input gen_t hg,
                           input logic typed, input pool_res_t fixed,
                           output pool_res_t got);
    int gap;
    if ($urandom_range(0, 29) == 0) burst = ~burst;
    gap = (no_idle || burst) ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_opcode <= op;
    in_handle_slot <= hs;
    in_handle_generation <= hg;
    do @(posedge clk); while (busy);
    got = pool_update(op, hs, hg);
    if (typed) got = fixed;
    pending_results.push_back(got);
    words_sent++;
    if (got.status == STAT_FULL) full_seen++;
    if (got.status == STAT_STALE) stale_seen++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic rand_word(input int add_w, input int rem_w);
    int r;
    slot_t s;
    gen_t g;
    pool_res_t res;
    r = $urandom_range(0, 99);
    s = pick_live();
    if (r < add_w) begin
      send_word(OP_ADD, slot_t'($urandom), gen_t'($urandom), 1'b0, '0, res);
    end else if (r < add_w + rem_w) begin
      if (s != '0) send_word(OP_REMOVE, s, slot_gen[s], 1'b0, '0, res);
      else send_word(OP_REMOVE, slot_t'($urandom), gen_t'($urandom), 1'b0, '0, res);
    end else if (r < add_w + rem_w + 14) begin
      send_word(OP_LOOKUP, s, slot_gen[s], 1'b0, '0, res);
    end else if (r < add_w + rem_w + 24) begin
      case ($urandom_range(0, 2))
        0: begin
          s = slot_t'($urandom_range(0, SLOT_COUNT - 1));
          g = gen_t'($urandom);
        end
        1: g = slot_gen[s] ^ gen_t'($urandom_range(1, 65535));
        default: begin
          s = free_top;
          g = slot_gen[s] - 1'b1;
        end
      endcase
      send_word($urandom_range(0, 1) ? OP_REMOVE : OP_LOOKUP, s, g, 1'b0, '0, res);
    end else if (r < add_w + rem_w + 28) begin
      send_word(OP_FIRST, slot_t'($urandom), gen_t'($urandom), 1'b0, '0, res);
    end else if (r < add_w + rem_w + 40) begin
      send_word(OP_NEXT, walk_pos, gen_t'($urandom), 1'b0, '0, res);
      walk_pos = (res.status == STAT_OK) ? res.slot : '0;
    end else if (r < add_w + rem_w + 44) begin
      send_word(OP_NEXT, slot_t'($urandom), gen_t'($urandom), 1'b0, '0, res);
    end else if (r < add_w + rem_w + 47) begin
      send_word(3'($urandom_range(5, 7)), slot_t'($urandom), gen_t'($urandom),
                1'b0, '0, res);
    end else begin
      send_word(OP_LOOKUP, slot_t'($urandom), gen_t'($urandom), 1'b0, '0, res);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result exp none act slot %0d gen %0d status %0d",
                 $time, out_result_slot, out_result_generation, out_status);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_result_slot !== want.slot) begin
          $display("%0t: slot mismatch exp %0d act %0d", $time, want.slot, out_result_slot);
          errors++;
        end
        if (out_result_generation !== want.gen) begin
          $display("%0t: generation mismatch exp %0d act %0d", $time, want.gen,
                   out_result_generation);
          errors++;
        end
        if (out_status !== want.status) begin
          $display("%0t: status mismatch exp %0d act %0d", $time, want.status, out_status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("generational_slot_pool verification failed");
      $finish;
    end
  end

  initial begin
    pool_res_t res;
    slot_t s;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      nxt_link[i] = '0;
      prv_link[i] = '0;
      slot_gen[i] = '0;
      slot_live[i] = 1'b0;
    end
    high_mark = 9'd1;
    free_top = '0;

    dir_tab.push_back('{OP_FIRST,  8'd0,   16'd0,     1'b1, '{8'd0, 16'd0, STAT_OK}});
    dir_tab.push_back('{OP_NEXT,   8'd0,   16'hffff,  1'b1, '{8'd0, 16'd0, STAT_OK}});
    dir_tab.push_back('{OP_LOOKUP, 8'd0,   16'd0,     1'b1, '{8'd0, 16'd0, STAT_STALE}});
    dir_tab.push_back('{OP_REMOVE, 8'd1,   16'd0,     1'b1, '{8'd0, 16'd0, STAT_STALE}});
    dir_tab.push_back('{OP_NEXT,   8'd255, 16'd0,     1'b1, '{8'd0, 16'd0, STAT_STALE}});
    dir_tab.push_back('{OP_BAD5,   8'd0,   16'd0,     1'b1, '{8'd0, 16'd0, STAT_STALE}});
    dir_tab.push_back('{OP_BAD7,   8'd255, 16'hffff,  1'b1, '{8'd0, 16'd0, STAT_STALE}});
    dir_tab.push_back('{OP_ADD,    8'd255, 16'hffff,  1'b1, '{8'd1, 16'd0, STAT_OK}});
    dir_tab.push_back('{OP_ADD,    8'd0,   16'd0,     1'b1, '{8'd2, 16'd0, STAT_OK}});
    dir_tab.push_back('{OP_LOOKUP, 8'd1,   16'd0,     1'b0, '0});
    dir_tab.push_back('{OP_LOOKUP, 8'd1,   16'd1,     1'b1, '{8'd0, 16'd0, STAT_STALE}});
    dir_tab.push_back('{OP_FIRST,  8'd0,   16'd0,     1'b0, '0});
    dir_tab.push_back('{OP_NEXT,   8'd1,   16'd0,     1'b0, '0});
    dir_tab.push_back('{OP_NEXT,   8'd2,   16'd0,     1'b0, '0});
    dir_tab.push_back('{OP_REMOVE, 8'd1,   16'd0,     1'b0, '0});
    dir_tab.push_back('{OP_REMOVE, 8'd1,   16'd0,     1'b1, '{8'd0, 16'd0, STAT_STALE}});
    dir_tab.push_back('{OP_NEXT,   8'd1,   16'd0,     1'b1, '{8'd0, 16'd0, STAT_STALE}});
    dir_tab.push_back('{OP_ADD,    8'd0,   16'd0,     1'b1, '{8'd1, 16'd1, STAT_OK}});
    dir_tab.push_back('{OP_LOOKUP, 8'd1,   16'd1,     1'b0, '0});
    dir_tab.push_back('{OP_REMOVE, 8'd255, 16'hffff,  1'b1, '{8'd0, 16'd0, STAT_STALE}});
    dir_tab.push_back('{OP_REMOVE, 8'd2,   16'd0,     1'b0, '0});
    dir_tab.push_back('{OP_REMOVE, 8'd1,   16'd1,     1'b0, '0});
    dir_tab.push_back('{OP_FIRST,  8'd0,   16'd0,     1'b1, '{8'd0, 16'd0, STAT_OK}});

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i])
      send_word(dir_tab[i].op, dir_tab[i].hs, dir_tab[i].hg, dir_tab[i].typed,
                dir_tab[i].res, res);
    drain();

    for (int i = 0; i < RAND_WORDS; i++) rand_word(32, 14);
    drain();

    // fill the pool until add reports full, then push a couple more
    res = '0;
    while (res.status != STAT_FULL)
      send_word(OP_ADD, slot_t'($urandom), gen_t'($urandom), 1'b0, '0, res);
    for (int i = 0; i < 2; i++)
      send_word(OP_ADD, slot_t'($urandom), gen_t'($urandom), 1'b0, '0, res);

    for (int i = 0; i < RAND_WORDS; i++) rand_word(20, 26);
    drain();

    // churn one slot through remove and add back to back
    no_idle = 1'b1;
    s = pick_live();
    if (s == '0) begin
      send_word(OP_ADD, '0, '0, 1'b0, '0, res);
      s = res.slot;
    end
    for (int i = 0; i < CHURN_ROUNDS; i++) begin
      send_word(OP_REMOVE, s, slot_gen[s], 1'b0, '0, res);
      send_word(OP_ADD, slot_t'($urandom), gen_t'($urandom), 1'b0, '0, res);
      s = res.slot;
    end
    no_idle = 1'b0;
    for (int i = 0; i < 40; i++) rand_word(25, 25);
    drain();

    $display("sent %0d words, checked %0d results (%0d full, %0d stale handle)",
             words_sent, results_seen, full_seen, stale_seen);
    $display("covered reset state, pool fill to full, list walks and slot reuse churn");
    if (errors == 0) begin
      $display("generational_slot_pool verification clean");
    end else begin
      $display("generational_slot_pool verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
